// ----- sv/pcg_pkg.sv -----
// Shared constants, types and arithmetic helpers for the PCG random generator.
package pcg_pkg;

	// Request operation codes
	localparam logic [1:0] OP_RAW    = 2'd0;
	localparam logic [1:0] OP_UNIT   = 2'd1;
	localparam logic [1:0] OP_RESEED = 2'd2;

	// Number of result pipeline stages, request capture to output register
	localparam int unsigned PCG_STAGES = 8;

	// LCG multiplier and increment
	localparam logic [63:0] PCG_MULT = 64'h5851_F42D_4C95_7F2D;
	localparam logic [63:0] PCG_INC  = 64'hDA3E_39CB_94B9_5BDB;

	// Jump-ahead multipliers, worked out at elaboration (mod 2^64)
	localparam logic [63:0] PCG_MULT2 = PCG_MULT * PCG_MULT;
	localparam logic [63:0] PCG_MULT3 = PCG_MULT2 * PCG_MULT;

	// Offsets of the first three states after a reseed with zero.
	// PCG_K0 is also the offset of a two-step jump.
	localparam logic [63:0] PCG_K0 = PCG_MULT * PCG_INC + PCG_INC;
	localparam logic [63:0] PCG_K1 = PCG_MULT * PCG_K0 + PCG_INC;
	localparam logic [63:0] PCG_K2 = PCG_MULT * PCG_K1 + PCG_INC;

	// Unit draw reduction constants
	localparam logic [19:0] PCG_UNIT_MOD = 20'd1000000;
	localparam logic [19:0] PCG_WRAP32   = 20'd967296;     // 2^32 mod 1e6
	localparam logic [27:0] PCG_RECIP    = 28'd140737489;  // ceil(2^41 / 15625)
	localparam int unsigned PCG_RECIP_SHIFT = 41;

	typedef logic [PCG_STAGES-1:0] stage_en_t;

	// Low 64 bits of a 64x64 product, kept as three 32x32 partial products
	typedef struct packed {
		logic [63:0] lo;
		logic [31:0] hi_a;
		logic [31:0] hi_b;
	} pp_t;

	function automatic pp_t pcg_pp(input logic [63:0] s, input logic [63:0] a);
		pp_t p;
		p.lo   = 64'(s[31:0]) * 64'(a[31:0]);
		p.hi_a = s[63:32] * a[31:0];
		p.hi_b = s[31:0] * a[63:32];
		return p;
	endfunction

	function automatic logic [63:0] pcg_pp_sum(input pp_t p);
		logic [31:0] hi;
		hi = p.hi_a + p.hi_b;
		return p.lo + {hi, 32'd0};
	endfunction

endpackage

// ----- sv/pcg_lcg.sv -----
// LCG state ring with two-step jump-ahead, and the first two result stages.
module pcg_lcg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               acc,
	input  pcg_pkg::stage_en_t en,
	input  logic [1:0]         operation,
	input  logic [63:0]        seed,
	output logic [63:0]        old_s2,
	output logic [1:0]         op_s2
);

	// cur_q holds the next state once settled; pb_q/nkc_q hold the one after.
	// Just after a reseed the next state is still pending in pa_q.
	logic [63:0]   cur_q;
	pcg_pkg::pp_t  pa_q;
	pcg_pkg::pp_t  pb_q;
	pcg_pkg::pp_t  pc_q;
	logic [63:0]   nkc_q;
	logic          pend_q;

	pcg_pkg::pp_t  pp1_s1;
	logic          kadd_s1;
	logic [1:0]    op_s1;

	logic [63:0]   nxt_sum;
	pcg_pkg::pp_t  pb_adv;
	pcg_pkg::pp_t  seed_pa;
	pcg_pkg::pp_t  seed_pb;
	pcg_pkg::pp_t  seed_pc;
	pcg_pkg::pp_t  cur_pp;

	// Settle the following state; start the jump from the current one
	assign nxt_sum = pcg_pkg::pcg_pp_sum(pb_q) + nkc_q;
	assign pb_adv  = pcg_pkg::pcg_pp(cur_q, pcg_pkg::PCG_MULT2);

	// Reseed: the first three states are seed times a power of the multiplier plus an offset
	assign seed_pa = pcg_pkg::pcg_pp(seed, pcg_pkg::PCG_MULT);
	assign seed_pb = pcg_pkg::pcg_pp(seed, pcg_pkg::PCG_MULT2);
	assign seed_pc = pcg_pkg::pcg_pp(seed, pcg_pkg::PCG_MULT3);

	assign cur_pp = '{lo: cur_q, hi_a: 32'd0, hi_b: 32'd0};

	// Advance the state ring on each accepted draw, reload it on a reseed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q  <= 64'd0;
			pa_q   <= '0;
			pb_q   <= '0;
			pc_q   <= '0;
			nkc_q  <= pcg_pkg::PCG_K1;
			pend_q <= 1'b1;
		end else if (acc) begin
			unique case (operation)
				pcg_pkg::OP_RAW, pcg_pkg::OP_UNIT: begin
					cur_q <= nxt_sum;
					if (pend_q) begin
						pb_q   <= pc_q;
						nkc_q  <= pcg_pkg::PCG_K2;
						pend_q <= 1'b0;
					end else begin
						pb_q  <= pb_adv;
						nkc_q <= pcg_pkg::PCG_K0;
					end
				end
				pcg_pkg::OP_RESEED: begin
					pa_q   <= seed_pa;
					pb_q   <= seed_pb;
					pc_q   <= seed_pc;
					nkc_q  <= pcg_pkg::PCG_K1;
					pend_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage 1: capture the drawn state, partial products if still pending
	always_ff @(posedge clk) begin
		if (en[0]) begin
			op_s1 <= operation;
			if (pend_q) begin
				pp1_s1  <= pa_q;
				kadd_s1 <= 1'b1;
			end else begin
				pp1_s1  <= cur_pp;
				kadd_s1 <= 1'b0;
			end
		end
	end

	// Stage 2: settle the drawn state
	always_ff @(posedge clk) begin
		if (en[1]) begin
			old_s2 <= pcg_pkg::pcg_pp_sum(pp1_s1) + (kadd_s1 ? pcg_pkg::PCG_K0 : 64'd0);
			op_s2  <= op_s1;
		end
	end

endmodule

// ----- sv/pcg_perm.sv -----
// Output permutation: xorshift, shift and 64-bit pseudo-rotate of the drawn state.
module pcg_perm (
	input  logic               clk,
	input  pcg_pkg::stage_en_t en,
	input  logic [63:0]        old_s2,
	input  logic [1:0]         op_s2,
	output logic [63:0]        val_s3,
	output logic               unit_s3
);

	logic [63:0] xs;
	logic [4:0]  rot;
	logic [4:0]  rot_l;
	logic [63:0] perm;
	logic        draw;

	// Xorshift by 18, drop 27 bits, rotate amount from the top five bits
	assign xs    = ((old_s2 >> 18) ^ old_s2) >> 27;
	assign rot   = old_s2[63:59];
	assign rot_l = 5'd0 - rot;
	assign perm  = (xs >> rot) | (xs << rot_l);
	assign draw  = (op_s2 == pcg_pkg::OP_RAW) || (op_s2 == pcg_pkg::OP_UNIT);

	// Stage 3: zero the value for a reseed or an unused code
	always_ff @(posedge clk) begin
		if (en[2]) begin
			val_s3  <= draw ? perm : 64'd0;
			unit_s3 <= (op_s2 == pcg_pkg::OP_UNIT);
		end
	end

endmodule

// ----- sv/pcg_umod.sv -----
// Modulo one million reduction for unit draws, with the output register.
module pcg_umod (
	input  logic               clk,
	input  pcg_pkg::stage_en_t en,
	input  logic [63:0]        val_s3,
	input  logic               unit_s3,
	output logic [63:0]        value_s8
);

	logic [52:0] y_s4;
	logic [63:0] v_s4;
	logic        u_s4;
	logic [41:0] z_s5;
	logic [63:0] v_s5;
	logic        u_s5;
	logic [32:0] w_s6;
	logic [63:0] v_s6;
	logic        u_s6;
	logic [13:0] q_s7;
	logic [32:0] w_s7;
	logic [63:0] v_s7;
	logic        u_s7;

	logic [54:0] qprod;
	logic [33:0] rem;

	// Quotient by reciprocal of 15625 after dropping six bits (1e6 = 64 * 15625)
	assign qprod = 55'(w_s6[32:6]) * 55'(pcg_pkg::PCG_RECIP);
	assign rem   = 34'(w_s7) - 34'(q_s7) * 34'(pcg_pkg::PCG_UNIT_MOD);

	// Fold the upper word three times using 2^32 mod 1e6
	always_ff @(posedge clk) begin
		if (en[3]) begin
			y_s4 <= 53'(val_s3[63:32]) * 53'(pcg_pkg::PCG_WRAP32) + 53'(val_s3[31:0]);
			v_s4 <= val_s3;
			u_s4 <= unit_s3;
		end
		if (en[4]) begin
			z_s5 <= 42'(y_s4[52:32]) * 42'(pcg_pkg::PCG_WRAP32) + 42'(y_s4[31:0]);
			v_s5 <= v_s4;
			u_s5 <= u_s4;
		end
		if (en[5]) begin
			w_s6 <= 33'(z_s5[41:32]) * 33'(pcg_pkg::PCG_WRAP32) + 33'(z_s5[31:0]);
			v_s6 <= v_s5;
			u_s6 <= u_s5;
		end
	end

	// Take the quotient, then the remainder into the output register
	always_ff @(posedge clk) begin
		if (en[6]) begin
			q_s7 <= qprod[pcg_pkg::PCG_RECIP_SHIFT +: 14];
			w_s7 <= w_s6;
			v_s7 <= v_s6;
			u_s7 <= u_s6;
		end
		if (en[7]) begin
			value_s8 <= u_s7 ? 64'(rem[19:0]) : v_s7;
		end
	end

endmodule

// ----- sv/pcg_random_generator.sv -----
// Top level of the PCG random generator: request handshake, stage valids, result port.
// Throughput: one request per clock, draws, reseeds and unused codes alike, while the
// output is not stalled. A result passes through the eight result registers (capture,
// state sum, permutation, three folds, quotient, remainder) on its way to value.
// Stalls on out_ready squeeze out bubbles before in_ready drops.
// Reset: the state takes the value of a reseed with zero and the pipeline empties.
module pcg_random_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [63:0] seed,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value
);

	pcg_pkg::stage_en_t vld_q;
	pcg_pkg::stage_en_t en;
	logic               acc;
	logic [63:0]        old_s2;
	logic [1:0]         op_s2;
	logic [63:0]        val_s3;
	logic               unit_s3;

	// A stage loads when it is empty or its contents move on
	assign en[pcg_pkg::PCG_STAGES-1] = ~vld_q[pcg_pkg::PCG_STAGES-1] | out_ready;
	for (genvar g = 0; g < pcg_pkg::PCG_STAGES - 1; g++) begin : g_en
		assign en[g] = ~vld_q[g] | en[g+1];
	end

	assign in_ready  = en[0];
	assign acc       = in_valid & en[0];
	assign out_valid = vld_q[pcg_pkg::PCG_STAGES-1];

	// Shift the stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[pcg_pkg::PCG_STAGES-2:0], in_valid}) | (~en & vld_q);
		end
	end

	pcg_lcg u_lcg (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.en        (en),
		.operation (operation),
		.seed      (seed),
		.old_s2    (old_s2),
		.op_s2     (op_s2)
	);

	pcg_perm u_perm (
		.clk     (clk),
		.en      (en),
		.old_s2  (old_s2),
		.op_s2   (op_s2),
		.val_s3  (val_s3),
		.unit_s3 (unit_s3)
	);

	pcg_umod u_umod (
		.clk      (clk),
		.en       (en),
		.val_s3   (val_s3),
		.unit_s3  (unit_s3),
		.value_s8 (value)
	);

endmodule

// ----- sv/pcg_checker.sv -----
// Port-level checks for the PCG random generator, bound to the top level.
module pcg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(value))
		else $error("result changed while stalled");

	// Back-pressure reaches the request side only through a stalled result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request refused with the output side free");

	// No result straight out of reset
	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !out_valid)
		else $error("result present just after reset");

endmodule

bind pcg_random_generator pcg_checker u_pcg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);

// ----- bench/pcg_random_generator_tb.sv -----
// Self-checking testbench for the PCG random generator: draws, unit draws and reseeds.
module pcg_random_generator_tb;

	// Spare operation code: the block leaves its state alone and returns zero
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int unsigned RESET_CYCLES = 11;
	localparam int unsigned DRAIN_LIMIT = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  operation = pcg_pkg::OP_RAW;
	logic [63:0] seed = 64'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] value;

	// Generator state as the predictor sees it
	logic [63:0] draw_state;
	logic [63:0] expected_draws[$];
	logic [63:0] wanted_value;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned error_count = 0;

	pcg_random_generator i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.seed       (seed),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.value      (value)
	);

	always #10 clk = ~clk;

	// Give up after a generous fixed time
	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	// Work out the value a request returns and advance the predicted state
	function automatic logic [63:0] next_draw(input logic [1:0] op, input logic [63:0] sd);
		logic [63:0] old_state;
		logic [63:0] mixed;
		logic [4:0]  rot_right;
		logic [4:0]  rot_left;
		logic [63:0] permuted;
		old_state = draw_state;
		mixed = ((old_state >> 18) ^ old_state) >> 27;
		rot_right = old_state[63:59];
		rot_left = 5'd0 - rot_right;
		permuted = (mixed >> rot_right) | (mixed << rot_left);
		unique case (op)
			pcg_pkg::OP_RAW: begin
				draw_state = old_state * pcg_pkg::PCG_MULT + pcg_pkg::PCG_INC;
				return permuted;
			end
			pcg_pkg::OP_UNIT: begin
				draw_state = old_state * pcg_pkg::PCG_MULT + pcg_pkg::PCG_INC;
				return permuted % 64'(pcg_pkg::PCG_UNIT_MOD);
			end
			pcg_pkg::OP_RESEED: begin
				draw_state = (pcg_pkg::PCG_INC + sd) * pcg_pkg::PCG_MULT + pcg_pkg::PCG_INC;
				return 64'd0;
			end
			default: return 64'd0;
		endcase
	endfunction

	// Predict on each accepted request; reset leaves the state of a zero reseed
	always @(posedge clk) begin
		if (!arst_n) begin
			draw_state = (pcg_pkg::PCG_INC + 64'd0) * pcg_pkg::PCG_MULT + pcg_pkg::PCG_INC;
		end else if (in_valid && in_ready) begin
			expected_draws = {expected_draws, next_draw(operation, seed)};
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_draws.size() == 0) begin
				$error("value: no result expected, actual %h", value);
				error_count++;
			end else begin
				wanted_value = expected_draws.pop_front();
				if (value !== wanted_value) begin
					$error("value mismatch: expected %h, actual %h", wanted_value, value);
					error_count++;
				end
			end
		end
	end

	// Offer one request, idling first at random, and hold it until accepted
	task automatic send_request(input logic [1:0] op, input logic [63:0] sd);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		seed <= sd;
		do @(posedge clk); while (!in_ready);
	endtask

	// Pick a seed, leaning on values that stress the wrap of inc + seed
	function automatic logic [63:0] pick_seed();
		logic [63:0] one_bit;
		one_bit = 64'd1 << $urandom_range(63);
		case ($urandom_range(7))
			0: return 64'd0;
			1: return '1;
			2: return (64'd0 - pcg_pkg::PCG_INC) + 64'($urandom_range(3)) - 64'd1;
			3: return one_bit;
			4: return ~one_bit;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Check the state left by reset through the first few draws
	task automatic test_reset_draws();
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_RAW, '1);
		send_request(pcg_pkg::OP_UNIT, 64'd0);
		send_request(pcg_pkg::OP_RAW, 64'h5555_5555_5555_5555);
	endtask

	// Cover every operation, the spare code and the seed extremes
	task automatic test_operations();
		send_request(OP_SPARE, '1);
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_RESEED, 64'd0);
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_UNIT, 64'd0);
		send_request(pcg_pkg::OP_RESEED, '1);
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_UNIT, '1);
		// inc + seed wraps to zero, so the state becomes the increment itself
		send_request(pcg_pkg::OP_RESEED, 64'd0 - pcg_pkg::PCG_INC);
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_RAW, 64'd0);
		send_request(pcg_pkg::OP_RESEED, 64'h8000_0000_0000_0000);
		send_request(pcg_pkg::OP_UNIT, 64'd0);
		send_request(pcg_pkg::OP_RESEED, 64'd1);
		send_request(pcg_pkg::OP_RAW, 64'hAAAA_AAAA_AAAA_AAAA);
		send_request(OP_SPARE, 64'd0);
		send_request(pcg_pkg::OP_RAW, 64'd0);
	endtask

	// Mostly draws, with reseeds and the odd spare code mixed in
	task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count);
		int unsigned pick;
		logic [1:0]  op;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int unsigned i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 45)
				op = pcg_pkg::OP_RAW;
			else if (pick < 85)
				op = pcg_pkg::OP_UNIT;
			else if (pick < 95)
				op = pcg_pkg::OP_RESEED;
			else
				op = OP_SPARE;
			send_request(op, pick_seed());
		end
	endtask

	// Wait for the outstanding results, then let the pipeline settle
	task automatic drain_results();
		in_valid <= 1'b0;
		for (int unsigned n = 0; n < DRAIN_LIMIT && expected_draws.size() != 0; n++)
			@(posedge clk);
		repeat (2 * pcg_pkg::PCG_STAGES) @(posedge clk);
		if (expected_draws.size() != 0) begin
			$error("value: %0d expected results never arrived", expected_draws.size());
			error_count++;
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_draws();
		test_operations();
		test_random_traffic(0, 0, 112);
		test_random_traffic(50, 0, 112);
		test_random_traffic(0, 50, 112);
		test_random_traffic(35, 35, 112);
		drain_results();
		if (error_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/pcg_pkg.sv
sv/pcg_lcg.sv
sv/pcg_perm.sv
sv/pcg_umod.sv
sv/pcg_random_generator.sv
sv/pcg_checker.sv
bench/pcg_random_generator_tb.sv
